/* src/ipat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipat_pkg
// Shared types, character codes and per-character update functions of the
// IPv4 / IPv6 address text parser.
// ----------------------------------------------------------------------------
package ipat_pkg;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  // End of text is fed as a ninth-bit code that no character can take
  localparam logic [8:0] EndMark = 9'h100;

  localparam logic [8:0]  DecOvf     = 9'h100;
  localparam logic [11:0] DecLimit   = 12'd255;
  localparam logic [2:0]  DecGroups  = 3'd4;
  localparam logic [16:0] HexOvf     = 17'h10000;
  localparam logic [3:0]  HexGroups  = 4'd8;
  localparam logic [3:0]  TailStart  = 4'd6;
  localparam logic [31:0] V4Loopback = 32'h7F00_0001;
  localparam logic [63:0] V6LoopLo   = 64'd1;

  typedef struct packed {
    logic [8:0]  acc;
    logic [2:0]  cnt;
    logic [31:0] bytes;
    logic        err;
  } dec_state_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic        err;
    logic        full;
  } dec_res_t;

  typedef struct packed {
    logic [16:0] acc;
    logic [3:0]  cnt;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        head_err;
    logic        tail_err;
  } hex_state_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        head_err;
    logic        tail_err;
    logic        full;
    logic        tail_zone;
  } hex_res_t;

  typedef struct packed {
    logic colon;
    logic tdot;
    logic tcolon;
  } mode_t;

  function automatic dec_state_t dec_feed(input logic [8:0] c, input dec_state_t s);
    dec_state_t r;
    logic [11:0] n;
    logic [4:0]  sh;
    logic        digit;
    r     = s;
    digit = (c >= {1'b0, CharZero}) && (c <= {1'b0, CharNine});
    n     = 12'(s.acc[7:0]) * 12'd10 + 12'(c[3:0]);
    sh    = {2'd3 - s.cnt[1:0], 3'b000};
    if (!s.err && (s.cnt < DecGroups)) begin
      if (digit) begin
        r.acc = (s.acc[8] || (n > DecLimit)) ? DecOvf : n[8:0];
      end else if (s.acc[8]) begin
        r.err = 1'b1;
      end else begin
        r.bytes[sh +: 8] = s.acc[7:0];
        r.acc            = '0;
        if (s.cnt < 3'd3) begin
          if (c != {1'b0, CharDot}) begin
            r.err = 1'b1;
          end else begin
            r.cnt = s.cnt + 3'd1;
          end
        end else begin
          r.cnt = DecGroups;
        end
      end
    end
    return r;
  endfunction

  // Returns {is_hex, nibble}
  function automatic logic [4:0] hex_digit(input logic [8:0] c);
    logic [4:0] r;
    r = '0;
    if ((c >= {1'b0, CharZero}) && (c <= {1'b0, CharNine})) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= {1'b0, CharLowA}) && (c <= {1'b0, CharLowF})) ||
                 ((c >= {1'b0, CharUpA}) && (c <= {1'b0, CharUpF}))) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic hex_state_t hex_feed(input logic [8:0] c, input hex_state_t s);
    hex_state_t  r;
    logic [4:0]  d;
    logic [19:0] n;
    logic [5:0]  sh;
    logic        head;
    r    = s;
    d    = hex_digit(c);
    n    = {s.acc[15:0], d[3:0]};
    sh   = {2'd3 - s.cnt[1:0], 4'b0000};
    head = s.cnt < TailStart;
    if (!s.head_err && !s.tail_err && (s.cnt < HexGroups)) begin
      if (d[4]) begin
        r.acc = (s.acc[16] || (n[19:16] != 4'd0)) ? HexOvf : n[16:0];
      end else if (s.acc[16]) begin
        if (head) r.head_err = 1'b1;
        else      r.tail_err = 1'b1;
      end else begin
        if (s.cnt[2]) r.lo[sh +: 16] = s.acc[15:0];
        else          r.hi[sh +: 16] = s.acc[15:0];
        r.acc = '0;
        if (s.cnt < 4'd7) begin
          if (c != {1'b0, CharColon}) begin
            if (head) r.head_err = 1'b1;
            else      r.tail_err = 1'b1;
          end else begin
            r.cnt = s.cnt + 4'd1;
          end
        end else begin
          r.cnt = HexGroups;
        end
      end
    end
    return r;
  endfunction

endpackage

/* src/ipat_dec_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipat_dec_lane
// Dotted-decimal group parser: accumulator, group count and collected bytes.
// Applies the current character when feed_i is set; the result also applies the end of text, for use on the last one.
// ----------------------------------------------------------------------------
module ipat_dec_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                feed_i,
  input  logic                last_i,
  input  logic [7:0]          ch_i,
  output ipat_pkg::dec_res_t  res_o
);
  import ipat_pkg::*;

  dec_state_t state_q, state_d;
  dec_state_t first, fin;

  always_comb begin
    first = feed_i ? dec_feed({1'b0, ch_i}, state_q) : state_q;
    fin   = dec_feed(EndMark, first);
  end

  always_comb begin
    state_d = state_q;
    if (step_i) begin
      // clear after the last character of a text
      state_d = last_i ? '0 : first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign res_o.bytes = fin.bytes;
  assign res_o.err   = fin.err;
  assign res_o.full  = (fin.cnt == DecGroups);

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cnt <= DecGroups)
    else $error("decimal group count out of range");

endmodule

/* src/ipat_hex_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipat_hex_lane
// Colon-separated hex group parser holding the eight 16-bit groups.
// Reports whether the tail zone (after the sixth colon) has been reached.
// ----------------------------------------------------------------------------
module ipat_hex_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                last_i,
  input  logic [7:0]          ch_i,
  output logic                tail_zone_o,
  output ipat_pkg::hex_res_t  res_o
);
  import ipat_pkg::*;

  hex_state_t state_q, state_d;
  hex_state_t first, fin;

  always_comb begin
    first = hex_feed({1'b0, ch_i}, state_q);
    fin   = hex_feed(EndMark, first);
  end

  always_comb begin
    state_d = state_q;
    if (step_i) begin
      state_d = last_i ? '0 : first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  // tail zone as seen before this character updates the group count
  assign tail_zone_o     = (state_q.cnt >= TailStart);

  assign res_o.hi        = fin.hi;
  assign res_o.lo        = fin.lo;
  assign res_o.head_err  = fin.head_err;
  assign res_o.tail_err  = fin.tail_err;
  assign res_o.full      = (fin.cnt == HexGroups);
  assign res_o.tail_zone = (fin.cnt >= TailStart);

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cnt <= HexGroups)
    else $error("hex group count out of range");

endmodule

/* src/ipat_result.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipat_result
// Picks IPv4, IPv6 or IPv6 with dotted tail, checks validity and loopback,
// and holds the result in the output register until it is transferred.
// ----------------------------------------------------------------------------
module ipat_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ipat_pkg::mode_t     mode_i,
  input  ipat_pkg::hex_res_t  hex_i,
  input  ipat_pkg::dec_res_t  v4_i,
  input  ipat_pkg::dec_res_t  tail_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                valid_res_o,
  output logic                is_v6_o,
  output logic [63:0]         addr_hi_o,
  output logic [63:0]         addr_lo_o,
  output logic                is_loopback_o
);
  import ipat_pkg::*;

  logic        ok, v6, loop;
  logic [63:0] hi, lo;
  logic        out_valid_q;
  logic        valid_res_q, is_v6_q, is_loopback_q;
  logic [63:0] addr_hi_q, addr_lo_q;

  always_comb begin
    v6 = mode_i.colon;
    hi = '0;
    lo = '0;
    ok = 1'b0;
    priority if (mode_i.colon && hex_i.head_err) begin
      ok = 1'b0;
    end else if (mode_i.colon && hex_i.tail_zone && mode_i.tdot) begin
      ok = !(mode_i.tcolon || tail_i.err);
      hi = hex_i.hi;
      lo = {hex_i.lo[63:32], tail_i.bytes};
    end else if (mode_i.colon) begin
      ok = !hex_i.tail_err && hex_i.full;
      hi = hex_i.hi;
      lo = hex_i.lo;
    end else begin
      ok = !v4_i.err && v4_i.full;
      lo = {32'd0, v4_i.bytes};
    end
    if (!ok) begin
      hi = '0;
      lo = '0;
    end
    loop = ok && (v6 ? ((hi == 64'd0) && (lo == V6LoopLo))
                     : (lo == {32'd0, V4Loopback}));
  end

  assign free_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      valid_res_q   <= ok;
      is_v6_q       <= v6;
      addr_hi_q     <= hi;
      addr_lo_q     <= lo;
      is_loopback_q <= loop;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = valid_res_q;
  assign is_v6_o       = is_v6_q;
  assign addr_hi_o     = addr_hi_q;
  assign addr_lo_o     = addr_lo_q;
  assign is_loopback_o = is_loopback_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !valid_res_q |-> (addr_hi_q == 64'd0) && (addr_lo_q == 64'd0))
    else $error("invalid result carries a nonzero address");

  a_loop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && is_loopback_q |-> valid_res_q)
    else $error("loopback flagged on an invalid result");

endmodule

/* src/ip_address_text_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_address_text_parser
// Parses IPv4 dotted-decimal or IPv6 colon-hex address text, one character
// per transfer, and gives one result per text on its last character.
// ----------------------------------------------------------------------------
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------
//   in      | in_valid_i / in_stall_o | ch_i, last_i
//   out     | out_valid_o/out_stall_i | valid_res_o, is_v6_o, addr_hi_o,
//           |                         | addr_lo_o, is_loopback_o
//
// One character per cycle while the input is not stalled: input register, parser
// update, and for the last character the result register, which is loaded from
// the parser update of that last character.
// Reset clears the input valid, all parser state and the output valid.
// While a result waits, characters of the next text keep flowing; only a
// last character stalls, until the output register is free.
// ----------------------------------------------------------------------------
module ip_address_text_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic        is_v6_o,
  output logic [63:0] addr_hi_o,
  output logic [63:0] addr_lo_o,
  output logic        is_loopback_o
);
  import ipat_pkg::*;

  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;
  logic       accept, advance, load, free;
  logic       tail_zone;
  mode_t      mode_q, mode_d, mode_fin;
  hex_res_t   hex_res;
  dec_res_t   v4_res, tail_res;

  assign advance    = in_valid_q && (!last_q || free);
  assign load       = advance && last_q;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  always_comb begin
    mode_fin.colon  = mode_q.colon | (ch_q == CharColon);
    mode_fin.tdot   = mode_q.tdot | (tail_zone && (ch_q == CharDot));
    mode_fin.tcolon = mode_q.tcolon | (tail_zone && (ch_q == CharColon));
    mode_d = mode_q;
    if (advance) begin
      mode_d = last_q ? '0 : mode_fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else begin
      mode_q <= mode_d;
    end
  end

  ipat_hex_lane u_hex (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .last_i      (last_q),
    .ch_i        (ch_q),
    .tail_zone_o (tail_zone),
    .res_o       (hex_res)
  );

  ipat_dec_lane u_v4 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .feed_i (1'b1),
    .last_i (last_q),
    .ch_i   (ch_q),
    .res_o  (v4_res)
  );

  // dotted quad after the sixth colon
  ipat_dec_lane u_tail (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .feed_i (tail_zone),
    .last_i (last_q),
    .ch_i   (ch_q),
    .res_o  (tail_res)
  );

  ipat_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .mode_i        (mode_fin),
    .hex_i         (hex_res),
    .v4_i          (v4_res),
    .tail_i        (tail_res),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .valid_res_o   (valid_res_o),
    .is_v6_o       (is_v6_o),
    .addr_hi_o     (addr_hi_o),
    .addr_lo_o     (addr_lo_o),
    .is_loopback_o (is_loopback_o)
  );

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o)
    else $error("last character did not produce a result");

  a_stall_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && last_q && out_valid_o)
    else $error("input stalled without a waiting last character");

endmodule
